// ===== rtl/ssdp_pkg.sv =====
// Shared types and constants for the step/direction pulse generator.
// No dependencies; imported by ssdp_core, ssdp_skid and the top level.
package ssdp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MODE_W      = 3;
    localparam int HALF_W      = 16;
    localparam int COUNT_W     = 31;
    localparam int PACKED_W    = 32;
    localparam int FRAC_W      = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MICROSTEP_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_ENABLE      = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SIXTEENTH = 3'b100;
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd2500;
    localparam logic [FRAC_W:0]   FRAC_FULL = 5'd16;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_STEP   = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_ORIGIN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // Packed MSB first: step_pin lands in bit 0.
    typedef struct packed {
        logic                accepted;
        logic                busy_res;
        logic [PACKED_W-1:0] position_packed;
        logic                enable_n_pin;
        logic [MODE_W-1:0]   mode_pins;
        logic                dir_pin;
        logic                step_pin;
    } result_t;

endpackage

// ===== rtl/stepper_step_dir_pulse_generator.sv =====
// Step/direction pulse generator, top level: command stream in, pin/position stream out.
// Depends on ssdp_pkg, ssdp_core and ssdp_skid.
//
//  channel | direction | handshake         | content
//  s_      | in        | s_tvalid/s_tready | one command transaction
//  m_      | out       | m_tvalid/m_tready | one result per command
//  cfg_    | in        | cfg_valid/cfg_ready (always ready) | register write
//
// Every command updates state in the cycle it is accepted; its result is registered
// in the output buffer before it appears on m_. One command per clock sustained while m_ is not stalled.
// A two-entry output buffer keeps s_tready high through a single stalled result;
// s_tready drops only while both entries are full.
// aresetn (synchronous) restores register defaults and an idle, zero position.
module stepper_step_dir_pulse_generator #(
    parameter int TIMER_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // direction, step_count
    input  logic [1:0]                       s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // step_pin, dir_pin, mode_pins[2:0], enable_n_pin, position_packed[31:0],
    // busy_res, accepted
    output logic [39:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssdp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssdp_pkg::*;

    logic    cmd_we;
    result_t core_result;
    result_t out_result;

    assign cfg_ready = 1'b1;
    assign cmd_we    = s_tvalid && s_tready;

    ssdp_core #(
        .TIMER_BITS   (TIMER_BITS),
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd_we   (cmd_we),
        .cmd      (cmd_t'(s_tuser)),
        .dir      (s_tdata[0]),
        .count    (s_tdata[COUNT_W:1]),
        .result   (core_result)
    );

    ssdp_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (core_result),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_result)
    );

    assign m_tdata = out_result;

endmodule

// ===== rtl/ssdp_core.sv =====
// Pulse generator state: config registers, position, pulse phase timer and
// multistep count. Produces the post-command result combinationally. Uses ssdp_pkg.
module ssdp_core #(
    parameter int TIMER_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ssdp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssdp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cmd_we,
    input  ssdp_pkg::cmd_t                  cmd,
    input  logic                            dir,
    input  logic [ssdp_pkg::COUNT_W-1:0]     count,
    output ssdp_pkg::result_t               result
);
    import ssdp_pkg::*;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    logic [MODE_W-1:0]        mode_reg;
    logic [HALF_W-1:0]        half_reg;
    logic                     enable_reg;
    logic [POSITION_BITS-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic                     dir_reg, dir_next;
    phase_t                   phase_reg, phase_next;
    logic [TIMER_BITS-1:0]    timer_reg, timer_next;
    logic [COUNT_W-1:0]       remain_reg, remain_next;

    logic [32:0]           half_ext;
    logic [TIMER_BITS-1:0] timer_load;
    logic [FRAC_W:0]       mult;
    logic [FRAC_W:0]       frac_up, frac_dn;
    logic                  busy_now;
    logic                  start;
    logic                  acc;
    logic                  pos_dir;
    phase_t                phase_mid;
    logic signed [PACKED_W-1:0] whole_ext;

    assign half_ext   = 33'(half_reg);
    assign timer_load = (half_ext > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX)
                                               : TIMER_BITS'(half_ext);
    assign mult = (mode_reg >= MODE_SIXTEENTH) ? (FRAC_W+1)'(1)
                                               : (FRAC_FULL >> mode_reg);
    assign busy_now = (phase_reg != PH_IDLE) || (remain_reg != '0);

    always_comb begin
        dir_next    = dir_reg;
        phase_next  = phase_reg;
        phase_mid   = phase_reg;
        timer_next  = timer_reg;
        remain_next = remain_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        start       = 1'b0;
        acc         = 1'b0;

        unique case (cmd)
            CMD_TICK: begin
                unique case (phase_reg)
                    PH_HIGH: begin
                        if (timer_reg <= TIMER_BITS'(1)) begin
                            phase_mid  = PH_LOW;
                            timer_next = timer_load;
                        end else begin
                            timer_next = timer_reg - TIMER_BITS'(1);
                        end
                    end
                    PH_LOW: begin
                        if (timer_reg <= TIMER_BITS'(1)) begin
                            phase_mid  = PH_IDLE;
                            timer_next = '0;
                        end else begin
                            timer_next = timer_reg - TIMER_BITS'(1);
                        end
                    end
                    default: ;
                endcase
                phase_next = phase_mid;
                // Back-to-back multistep: next pulse starts on the tick that ends the last
                if (phase_mid == PH_IDLE && remain_reg != '0) begin
                    remain_next = remain_reg - COUNT_W'(1);
                    start       = 1'b1;
                end
            end
            CMD_STEP: begin
                if (!busy_now) begin
                    dir_next = dir;
                    start    = 1'b1;
                    acc      = 1'b1;
                end
            end
            CMD_LOAD: begin
                if (!busy_now) begin
                    dir_next = dir;
                    acc      = 1'b1;
                    if (count != '0) begin
                        remain_next = count - COUNT_W'(1);
                        start       = 1'b1;
                    end
                end
            end
            CMD_ORIGIN: begin
                whole_next = '0;
                acc        = 1'b1;
            end
            default: ;
        endcase

        pos_dir = dir_next;
        frac_up = {1'b0, frac_reg} + mult;
        frac_dn = {1'b0, frac_reg} - mult;
        if (start) begin
            phase_next = PH_HIGH;
            timer_next = timer_load;
            if (!pos_dir) begin
                frac_next = frac_up[FRAC_W-1:0];
                if (frac_up[FRAC_W]) begin
                    whole_next = whole_reg + POSITION_BITS'(1);
                end
            end else begin
                // borrow wraps the fraction by sixteen
                frac_next = frac_dn[FRAC_W-1:0];
                if (frac_dn[FRAC_W]) begin
                    whole_next = whole_reg - POSITION_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            half_reg   <= HALF_PERIOD_RESET;
            enable_reg <= 1'b0;
            whole_reg  <= '0;
            frac_reg   <= '0;
            dir_reg    <= 1'b0;
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            remain_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MICROSTEP_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                    CFG_HALF_PERIOD_TICKS: half_reg   <= cfg_data[HALF_W-1:0];
                    CFG_DRIVE_ENABLE:      enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd_we) begin
                whole_reg  <= whole_next;
                frac_reg   <= frac_next;
                dir_reg    <= dir_next;
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                remain_reg <= remain_next;
            end
        end
    end

    assign whole_ext = PACKED_W'($signed(whole_next));

    always_comb begin
        result.step_pin        = (phase_next == PH_HIGH);
        result.dir_pin         = dir_next;
        result.mode_pins       = mode_reg;
        result.enable_n_pin    = ~enable_reg;
        result.position_packed = {whole_ext[PACKED_W-FRAC_W-1:0], frac_next};
        result.busy_res        = (phase_next != PH_IDLE) || (remain_next != '0);
        result.accepted        = acc;
    end

endmodule

// ===== rtl/ssdp_skid.sv =====
// Two-entry output register (main + skid) for the result stream.
// Uses ssdp_pkg::result_t.
module ssdp_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssdp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ssdp_pkg::result_t out_data
);
    import ssdp_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    advance;

    assign in_ready  = !skid_valid_reg;
    assign advance   = out_ready || !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== tb/tb_stepper_step_dir_pulse_generator.sv =====
// Self-checking testbench for stepper_step_dir_pulse_generator: directed table, then random
// command phases with random stalls on both streams, checked against a cycle-free motor model.
// Depends on ssdp_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_stepper_step_dir_pulse_generator;
    import ssdp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // direction, step_count
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // step_pin, dir_pin, mode_pins, enable_n_pin, position, busy, accepted
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stepper_step_dir_pulse_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Motor model state, shadowing the block's registers and counters
    logic [MODE_W-1:0]  mode_q  = '0;
    logic [HALF_W-1:0]  half_q  = HALF_PERIOD_RESET;
    logic               en_q    = 1'b0;
    logic [31:0]        whole_q = '0;
    logic [FRAC_W-1:0]  frac_q  = '0;
    logic               dir_q   = 1'b0;
    phase_t             phase_q = PH_IDLE;
    logic [HALF_W-1:0]  timer_q = '0;
    logic [COUNT_W-1:0] left_q  = '0;

    result_t pending_pins[$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      items_sent   = 0;
    logic    calm         = 1'b0;   // no stalls on either stream

    typedef struct {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        cmd_t                   cmd;
        logic                   dir;
        logic [COUNT_W-1:0]     count;
        logic                   typed;
        result_t                want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic logic motor_busy();
        return phase_q != PH_IDLE || left_q != 0;
    endfunction

    function automatic void advance_position();
        logic [FRAC_W:0] inc;
        logic [FRAC_W:0] f;
        inc = (mode_q >= MODE_SIXTEENTH) ? 5'd1 : (FRAC_FULL >> mode_q);
        if (!dir_q) begin
            f = {1'b0, frac_q} + inc;
            if (f >= FRAC_FULL) begin
                f = f - FRAC_FULL;
                whole_q = whole_q + 32'd1;
            end
            frac_q = f[FRAC_W-1:0];
        end else if ({1'b0, frac_q} < inc) begin
            f = {1'b0, frac_q} + FRAC_FULL - inc;
            frac_q = f[FRAC_W-1:0];
            whole_q = whole_q - 32'd1;
        end else begin
            f = {1'b0, frac_q} - inc;
            frac_q = f[FRAC_W-1:0];
        end
    endfunction

    function automatic void start_pulse();
        phase_q = PH_HIGH;
        timer_q = half_q;
        advance_position();
    endfunction

    function automatic void motor_tick();
        if (phase_q == PH_HIGH) begin
            if (timer_q <= 1) begin
                phase_q = PH_LOW;
                timer_q = half_q;
            end else begin
                timer_q = timer_q - HALF_W'(1);
            end
        end else if (phase_q == PH_LOW) begin
            if (timer_q <= 1) begin
                phase_q = PH_IDLE;
                timer_q = '0;
            end else begin
                timer_q = timer_q - HALF_W'(1);
            end
        end
        // next pulse of a multistep run starts on the tick that ends the previous one
        if (phase_q == PH_IDLE && left_q != 0) begin
            left_q = left_q - COUNT_W'(1);
            start_pulse();
        end
    endfunction

    function automatic void motor_config(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_MICROSTEP_MODE:    mode_q = val[MODE_W-1:0];
            CFG_HALF_PERIOD_TICKS: half_q = val[HALF_W-1:0];
            CFG_DRIVE_ENABLE:      en_q   = val[0];
            default: ;
        endcase
    endfunction

    function automatic result_t motor_command(cmd_t c, logic d, logic [COUNT_W-1:0] n);
        result_t r;
        logic    took;
        took = 1'b0;
        case (c)
            CMD_TICK: motor_tick();
            CMD_STEP: if (!motor_busy()) begin
                dir_q = d;
                start_pulse();
                took = 1'b1;
            end
            CMD_LOAD: if (!motor_busy()) begin
                dir_q = d;
                if (n != 0) begin
                    left_q = n - COUNT_W'(1);
                    start_pulse();
                end
                took = 1'b1;
            end
            default: begin
                whole_q = '0;
                took = 1'b1;
            end
        endcase
        r.step_pin        = (phase_q == PH_HIGH);
        r.dir_pin         = dir_q;
        r.mode_pins       = mode_q;
        r.enable_n_pin    = ~en_q;
        r.position_packed = {whole_q[PACKED_W-FRAC_W-1:0], frac_q};
        r.busy_res        = motor_busy();
        r.accepted        = took;
        return r;
    endfunction

    function automatic result_t pins(logic step, logic dir, logic [MODE_W-1:0] mode,
                                     logic en_n, logic [PACKED_W-1:0] pos,
                                     logic busy, logic acc);
        result_t r;
        r.step_pin        = step;
        r.dir_pin         = dir;
        r.mode_pins       = mode;
        r.enable_n_pin    = en_n;
        r.position_packed = pos;
        r.busy_res        = busy;
        r.accepted        = acc;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(cmd_t c, logic d, logic [COUNT_W-1:0] n,
                                          logic typed, result_t want);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = '0;
        row.val    = '0;
        row.cmd    = c;
        row.dir    = d;
        row.count  = n;
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = cmd_row(CMD_TICK, 1'b0, '0, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    function automatic logic [COUNT_W-1:0] small_count();
        if ($urandom_range(0, 19) == 0)
            return COUNT_W'($urandom_range(0, 40));
        return COUNT_W'($urandom_range(0, 5));
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 50)
            $display("[%0t] result %0d: %s got %h want %h",
                     $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_cmd(cmd_t c, logic d, logic [COUNT_W-1:0] n,
                            logic typed, result_t want);
        int      gap;
        result_t predicted;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {n, d};
        do @(posedge aclk); while (!s_tready);
        predicted = motor_command(c, d, n);
        pending_pins.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // Register writes only with the stream drained, plus an extra wait for the pipeline
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        motor_config(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int                 r;
        cmd_t               c;
        logic [COUNT_W-1:0] n;
        r = $urandom_range(0, 99);
        if (r < 50)      c = CMD_TICK;
        else if (r < 65) c = CMD_STEP;
        else if (r < 80) c = CMD_LOAD;
        else             c = CMD_ORIGIN;
        n = COUNT_W'($urandom());
        // an accepted load with a huge count would keep the motor busy for good
        if (c == CMD_LOAD && !motor_busy())
            n = small_count();
        send_cmd(c, 1'($urandom_range(0, 1)), n, 1'b0, '0);
    endtask

    // Start a move, then tick it out with a little noise mixed in
    task automatic motion_burst();
        send_cmd($urandom_range(0, 1) ? CMD_STEP : CMD_LOAD, 1'($urandom_range(0, 1)),
                 small_count(), 1'b0, '0);
        while (motor_busy()) begin
            if ($urandom_range(0, 9) == 0)
                random_item();
            else
                send_cmd(CMD_TICK, 1'($urandom_range(0, 1)), COUNT_W'($urandom()),
                         1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            results_seen++;
            if (pending_pins.size() == 0) begin
                flag_mismatch("unexpected transaction", m_tdata[31:0], '0);
            end else begin
                want = pending_pins.pop_front();
                if (got.step_pin !== want.step_pin)
                    flag_mismatch("step_pin", 32'(got.step_pin), 32'(want.step_pin));
                if (got.dir_pin !== want.dir_pin)
                    flag_mismatch("dir_pin", 32'(got.dir_pin), 32'(want.dir_pin));
                if (got.mode_pins !== want.mode_pins)
                    flag_mismatch("mode_pins", 32'(got.mode_pins), 32'(want.mode_pins));
                if (got.enable_n_pin !== want.enable_n_pin)
                    flag_mismatch("enable_n_pin", 32'(got.enable_n_pin),
                                  32'(want.enable_n_pin));
                if (got.position_packed !== want.position_packed)
                    flag_mismatch("position_packed", got.position_packed,
                                  want.position_packed);
                if (got.busy_res !== want.busy_res)
                    flag_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                if (got.accepted !== want.accepted)
                    flag_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
            end
        end
    end

    // Result-side backpressure
    initial begin
        int hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 8);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL stepper_step_dir_pulse_generator");
        $finish;
    end

    initial begin
        int                     phase;
        int                     target;
        int                     spins;
        logic [CFG_DATA_W-1:0]  hp;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Directed part: register defaults, busy rejection, origin while busy,
        // zero-count load, multistep run, downward fraction wrap, zero half period
        plan.push_back(cmd_row(CMD_TICK, 1'b1, 31'h7FFF_FFFF, 1'b1,
                               pins(1'b0, 1'b0, 3'd0, 1'b1, 32'h0, 1'b0, 1'b0)));
        plan.push_back(cmd_row(CMD_LOAD, 1'b1, 31'd0, 1'b1,
                               pins(1'b0, 1'b1, 3'd0, 1'b1, 32'h0, 1'b0, 1'b1)));
        plan.push_back(cmd_row(CMD_ORIGIN, 1'b0, 31'd5, 1'b1,
                               pins(1'b0, 1'b1, 3'd0, 1'b1, 32'h0, 1'b0, 1'b1)));
        plan.push_back(cfg_row(CFG_HALF_PERIOD_TICKS, 16'd2));
        plan.push_back(cfg_row(CFG_DRIVE_ENABLE, 16'd1));
        plan.push_back(cmd_row(CMD_STEP, 1'b0, 31'd0, 1'b1,
                               pins(1'b1, 1'b0, 3'd0, 1'b0, 32'h10, 1'b1, 1'b1)));
        plan.push_back(cmd_row(CMD_STEP, 1'b1, 31'd0, 1'b1,
                               pins(1'b1, 1'b0, 3'd0, 1'b0, 32'h10, 1'b1, 1'b0)));
        plan.push_back(cmd_row(CMD_LOAD, 1'b1, 31'd7, 1'b1,
                               pins(1'b1, 1'b0, 3'd0, 1'b0, 32'h10, 1'b1, 1'b0)));
        plan.push_back(cmd_row(CMD_ORIGIN, 1'b0, 31'd0, 1'b1,
                               pins(1'b1, 1'b0, 3'd0, 1'b0, 32'h0, 1'b1, 1'b1)));
        repeat (4) plan.push_back(cmd_row(CMD_TICK, 1'b0, 31'd0, 1'b0, '0));
        plan.push_back(cmd_row(CMD_LOAD, 1'b1, 31'd3, 1'b0, '0));
        repeat (12) plan.push_back(cmd_row(CMD_TICK, 1'b1, 31'd0, 1'b0, '0));
        plan.push_back(cfg_row(CFG_MICROSTEP_MODE, 16'd7));
        plan.push_back(cfg_row(CFG_HALF_PERIOD_TICKS, 16'd0));
        plan.push_back(cmd_row(CMD_STEP, 1'b1, 31'd0, 1'b0, '0));
        repeat (2) plan.push_back(cmd_row(CMD_TICK, 1'b0, 31'd0, 1'b0, '0));
        plan.push_back(cfg_row(CFG_MICROSTEP_MODE, 16'd3));
        plan.push_back(cmd_row(CMD_STEP, 1'b0, 31'd0, 1'b0, '0));
        repeat (2) plan.push_back(cmd_row(CMD_TICK, 1'b0, 31'd0, 1'b0, '0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                send_cmd(plan[i].cmd, plan[i].dir, plan[i].count, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < 13; phase++) begin
            calm = (phase % 4 == 3);
            write_reg(CFG_MICROSTEP_MODE,
                      (phase == 0) ? 16'd0 : (phase == 1) ? 16'd7 :
                      CFG_DATA_W'($urandom_range(0, 7)));
            case ($urandom_range(0, 5))
                0:       hp = 16'd0;
                1:       hp = 16'd1;
                default: hp = CFG_DATA_W'($urandom_range(2, 6));
            endcase
            write_reg(CFG_HALF_PERIOD_TICKS, hp);
            write_reg(CFG_DRIVE_ENABLE, CFG_DATA_W'(phase[0]));
            target = items_sent + 140;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 30)
                    motion_burst();
                else
                    random_item();
            end
        end

        // Widest half period and the largest count: the motor stays busy to the end
        calm = 1'b0;
        while (motor_busy())
            send_cmd(CMD_TICK, 1'($urandom_range(0, 1)), COUNT_W'($urandom()), 1'b0, '0);
        write_reg(CFG_MICROSTEP_MODE, CFG_DATA_W'(MODE_SIXTEENTH));
        write_reg(CFG_HALF_PERIOD_TICKS, 16'hFFFF);
        write_reg(CFG_DRIVE_ENABLE, 16'd1);
        send_cmd(CMD_LOAD, 1'b0, 31'h7FFF_FFFF, 1'b0, '0);
        repeat (60) random_item();

        s_tvalid <= 1'b0;
        spins = 0;
        while (pending_pins.size() != 0 && spins < 2000) begin
            @(negedge aclk);
            spins++;
        end
        repeat (8) @(negedge aclk);
        if (pending_pins.size() != 0)
            flag_mismatch("results never arrived", pending_pins.size(), 0);

        if (mismatches == 0)
            $display("PASS stepper_step_dir_pulse_generator");
        else
            $display("FAIL stepper_step_dir_pulse_generator");
        $finish;
    end

endmodule
